@@ rtl/lgp_pkg.sv @@
package lgp_pkg;

  // texture limits
  localparam int unsigned MaxSize  = 256;
  localparam int unsigned CoordW   = 9;   // clamped coordinate, 0..MaxSize
  localparam int unsigned PixW     = 8;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = ColorW / ChanW;

  // datapath widths
  localparam int unsigned AxisW    = CoordW + 1;          // signed axis delta
  localparam int unsigned ProdW    = 2 * AxisW;           // signed 10x10 product
  localparam int unsigned DotW     = ProdW + 2;           // signed projections
  localparam int unsigned DenW     = 19;                  // 2*(a^2+b^2) <= 2^18
  localparam int unsigned WgtW     = ChanW + DenW;        // channel times weight
  localparam int unsigned NumW     = WgtW + 1;            // sum of two weights

  // configuration port
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_COLOR = 3'd0,
    CFG_STOP_COLOR  = 3'd1,
    CFG_AXIS_XS     = 3'd2,
    CFG_AXIS_YS     = 3'd3,
    CFG_AXIS_XE     = 3'd4,
    CFG_AXIS_YE     = 3'd5,
    CFG_TEX_SIZE    = 3'd6
  } cfg_idx_e;

  // register reset values
  localparam logic [ColorW-1:0] StartColorRst = 32'h0000_00FF;
  localparam logic [ColorW-1:0] StopColorRst  = 32'hFFFF_FFFF;
  localparam logic [CoordW-1:0] AxisStartRst  = 9'd0;
  localparam logic [CoordW-1:0] AxisEndRst    = 9'd4;
  localparam logic [CoordW-1:0] TexSizeRst    = 9'd4;

  // clamp a coordinate to [0, size]
  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v,
                                                    input logic [CoordW-1:0] size);
    clamp_coord = (v > size) ? size : v;
  endfunction

endpackage

@@ rtl/linear_gradient_pixel.sv @@
// Throughput: one item per cycle unless the output stalls; six projection/blend
// stages feed an eight-stage restoring divider, one quotient bit per stage, then
// the output register. A stall at the output holds every stage in place.
// Reset (asynchronous, active low) clears all valid bits and loads the register defaults.
module linear_gradient_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lgp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lgp_pkg::ColorW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lgp_pkg::PixW-1:0]      pixel_x_i,
  input  logic [lgp_pkg::PixW-1:0]      pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lgp_pkg::ColorW-1:0]    pixel_abgr_o
);
  import lgp_pkg::*;

  localparam int unsigned DivSt = ChanW;   // one stage per quotient bit

  // ---------------- configuration registers
  logic [ColorW-1:0] start_q, stop_q;
  logic [CoordW-1:0] xs_cfg_q, ys_cfg_q, xe_cfg_q, ye_cfg_q, size_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= StartColorRst;
      stop_q     <= StopColorRst;
      xs_cfg_q   <= AxisStartRst;
      ys_cfg_q   <= AxisStartRst;
      xe_cfg_q   <= AxisEndRst;
      ye_cfg_q   <= AxisEndRst;
      size_cfg_q <= TexSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_COLOR: start_q    <= cfg_wdata_i;
        CFG_STOP_COLOR:  stop_q     <= cfg_wdata_i;
        CFG_AXIS_XS:     xs_cfg_q   <= cfg_wdata_i[CoordW-1:0];
        CFG_AXIS_YS:     ys_cfg_q   <= cfg_wdata_i[CoordW-1:0];
        CFG_AXIS_XE:     xe_cfg_q   <= cfg_wdata_i[CoordW-1:0];
        CFG_AXIS_YE:     ye_cfg_q   <= cfg_wdata_i[CoordW-1:0];
        CFG_TEX_SIZE:    size_cfg_q <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- global pipeline enable
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- clamp axis endpoints
  logic [CoordW-1:0] size_c, xs_c, ys_c, xe_c, ye_c;
  always_comb begin
    size_c = (size_cfg_q > CoordW'(MaxSize)) ? CoordW'(MaxSize) : size_cfg_q;
    xs_c   = clamp_coord(xs_cfg_q, size_c);
    ys_c   = clamp_coord(ys_cfg_q, size_c);
    xe_c   = clamp_coord(xe_cfg_q, size_c);
    ye_c   = clamp_coord(ye_cfg_q, size_c);
  end

  // ---------------- stage 1: pixel, endpoints, axis deltas
  logic                     v1_q;
  logic [PixW-1:0]          px1_q, py1_q;
  logic signed [AxisW-1:0]  xs1_q, ys1_q, xe1_q, ye1_q, a1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= pixel_x_i;
      py1_q <= pixel_y_i;
      xs1_q <= $signed({1'b0, xs_c});
      ys1_q <= $signed({1'b0, ys_c});
      xe1_q <= $signed({1'b0, xe_c});
      ye1_q <= $signed({1'b0, ye_c});
      a1_q  <= $signed({1'b0, xe_c}) - $signed({1'b0, xs_c});
      b1_q  <= $signed({1'b0, ye_c}) - $signed({1'b0, ys_c});
    end
  end

  // ---------------- stage 2: six parallel products
  logic signed [AxisW-1:0] cx, cy;
  assign cx = $signed({1'b0, px1_q, 1'b1});   // doubled pixel centre
  assign cy = $signed({1'b0, py1_q, 1'b1});

  logic                    v2_q;
  logic signed [ProdW-1:0] m_dx_q, m_dy_q, m_xs_q, m_ys_q, m_xe_q, m_ye_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_dx_q <= a1_q * cx;
      m_dy_q <= b1_q * cy;
      m_xs_q <= a1_q * xs1_q;
      m_ys_q <= b1_q * ys1_q;
      m_xe_q <= a1_q * xe1_q;
      m_ye_q <= b1_q * ye1_q;
    end
  end

  // ---------------- stage 3: projections d, d1, d2
  logic                  v3_q;
  logic signed [DotW-1:0] d_q, d1_q, d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q  <= DotW'(m_dx_q) + DotW'(m_dy_q);
      d1_q <= (DotW'(m_xs_q) + DotW'(m_ys_q)) <<< 1;
      d2_q <= (DotW'(m_xe_q) + DotW'(m_ye_q)) <<< 1;
    end
  end

  // ---------------- stage 4: region flags and blend weights
  logic signed [DotW-1:0] nhi_w, nlo_w, den_w;
  assign nhi_w = d2_q - d_q;
  assign nlo_w = d_q - d1_q;
  assign den_w = d2_q - d1_q;

  logic            v4_q, le4_q, ge4_q;
  logic [DenW-1:0] nhi4_q, nlo4_q, den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      le4_q  <= (d_q <= d1_q);
      ge4_q  <= (d_q >= d2_q);
      nhi4_q <= nhi_w[DenW-1:0];
      nlo4_q <= nlo_w[DenW-1:0];
      den4_q <= den_w[DenW-1:0];
    end
  end

  // ---------------- stage 5: channel weight products
  logic            v5_q, le5_q, ge5_q;
  logic [DenW-1:0] den5_q;
  logic [WgtW-1:0] ps5_q [NumChan];
  logic [WgtW-1:0] pt5_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      le5_q  <= le4_q;
      ge5_q  <= ge4_q;
      den5_q <= den4_q;
      for (int k = 0; k < NumChan; k++) begin
        ps5_q[k] <= WgtW'(start_q[k*ChanW +: ChanW]) * WgtW'(nhi4_q);
        pt5_q[k] <= WgtW'(stop_q[k*ChanW +: ChanW]) * WgtW'(nlo4_q);
      end
    end
  end

  // ---------------- stage 6: numerators
  logic            v6_q, le6_q, ge6_q;
  logic [DenW-1:0] den6_q;
  logic [NumW-1:0] num6_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      le6_q  <= le5_q;
      ge6_q  <= ge5_q;
      den6_q <= den5_q;
      for (int k = 0; k < NumChan; k++) begin
        num6_q[k] <= NumW'(ps5_q[k]) + NumW'(pt5_q[k]);
      end
    end
  end

  // ---------------- divider: one quotient bit per stage, MSB first
  logic             dv_q  [DivSt];
  logic             dle_q [DivSt];
  logic             dge_q [DivSt];
  logic [DenW-1:0]  dden_q[DivSt];
  logic [NumW-1:0]  rem_q [DivSt][NumChan];
  logic [ChanW-1:0] quo_q [DivSt][NumChan];

  // stage inputs
  logic             dv_in  [DivSt];
  logic             dle_in [DivSt];
  logic             dge_in [DivSt];
  logic [DenW-1:0]  dden_in[DivSt];
  logic [NumW-1:0]  rem_in [DivSt][NumChan];
  logic [ChanW-1:0] quo_in [DivSt][NumChan];
  logic [NumW-1:0]  rem_d  [DivSt][NumChan];
  logic [ChanW-1:0] quo_d  [DivSt][NumChan];

  always_comb begin
    for (int j = 0; j < DivSt; j++) begin
      if (j == 0) begin
        dv_in[j]   = v6_q;
        dle_in[j]  = le6_q;
        dge_in[j]  = ge6_q;
        dden_in[j] = den6_q;
        for (int k = 0; k < NumChan; k++) begin
          rem_in[j][k] = num6_q[k];
          quo_in[j][k] = '0;
        end
      end else begin
        dv_in[j]   = dv_q[j-1];
        dle_in[j]  = dle_q[j-1];
        dge_in[j]  = dge_q[j-1];
        dden_in[j] = dden_q[j-1];
        for (int k = 0; k < NumChan; k++) begin
          rem_in[j][k] = rem_q[j-1][k];
          quo_in[j][k] = quo_q[j-1][k];
        end
      end
    end
  end

  // trial subtract of the shifted divisor
  always_comb begin
    logic [NumW-1:0] dsh;
    for (int j = 0; j < DivSt; j++) begin
      dsh = NumW'(dden_in[j]) << (DivSt - 1 - j);
      for (int k = 0; k < NumChan; k++) begin
        quo_d[j][k] = quo_in[j][k];
        if (rem_in[j][k] >= dsh) begin
          rem_d[j][k] = rem_in[j][k] - dsh;
          quo_d[j][k][DivSt-1-j] = 1'b1;
        end else begin
          rem_d[j][k] = rem_in[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DivSt; j++) dv_q[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < DivSt; j++) dv_q[j] <= dv_in[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < DivSt; j++) begin
        dle_q[j]  <= dle_in[j];
        dge_q[j]  <= dge_in[j];
        dden_q[j] <= dden_in[j];
        for (int k = 0; k < NumChan; k++) begin
          rem_q[j][k] <= rem_d[j][k];
          quo_q[j][k] <= quo_d[j][k];
        end
      end
    end
  end

  // ---------------- output register: region select and byte reorder
  logic              out_v_q;
  logic [ColorW-1:0] abgr_q;
  logic [ColorW-1:0] abgr_d;

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      if (dle_q[DivSt-1]) begin
        abgr_d[ColorW-ChanW*(k+1) +: ChanW] = start_q[k*ChanW +: ChanW];
      end else if (dge_q[DivSt-1]) begin
        abgr_d[ColorW-ChanW*(k+1) +: ChanW] = stop_q[k*ChanW +: ChanW];
      end else begin
        abgr_d[ColorW-ChanW*(k+1) +: ChanW] = quo_q[DivSt-1][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv_q[DivSt-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) abgr_q <= abgr_d;
  end

  assign out_valid_o  = out_v_q;
  assign pixel_abgr_o = abgr_q;

endmodule
